[rtl/assert_macros.svh]
// Assertion macros used by the pairing sequencer RTL.
// Standalone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define BPSM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpsm assertion failed");

// Next-cycle implication, checked out of reset
`define BPSM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpsm assertion failed");

`endif

[rtl/bpsm_pkg.sv]
// Types, codes and helper functions of the BR/EDR pairing sequencer.
// No dependencies; used by the channel interfaces and the top level.
package bpsm_pkg;

  // Pairing mode
  typedef enum logic [3:0] {
    M_IDLE                  = 4'd0,
    M_INIT_STARTED          = 4'd1,
    M_INIT_WAIT_IOCAP_RESP  = 4'd2,
    M_RESP_WAIT_IOCAP_REQ   = 4'd3,
    M_WAIT_CONFIRM          = 4'd4,
    M_WAIT_PASSKEY_REQ      = 4'd5,
    M_WAIT_PASSKEY_NOTIFY   = 4'd6,
    M_WAIT_PAIRING_COMPLETE = 4'd7,
    M_WAIT_LINK_KEY         = 4'd8,
    M_INIT_WAIT_AUTH        = 4'd9,
    M_WAIT_ENCRYPTION       = 4'd10,
    M_FAILED                = 4'd11
  } mode_t;

  // Expected user event
  typedef enum logic [1:0] {
    EV_CONFIRM        = 2'd0,
    EV_PASSKEY_REQ    = 2'd1,
    EV_PASSKEY_NOTIFY = 2'd2
  } user_ev_t;

  // Event opcodes
  localparam logic [3:0] OP_INITIATE     = 4'd0;
  localparam logic [3:0] OP_IOCAP_REQ    = 4'd1;
  localparam logic [3:0] OP_IOCAP_RESP   = 4'd2;
  localparam logic [3:0] OP_CONFIRM      = 4'd3;
  localparam logic [3:0] OP_PASSKEY_REQ  = 4'd4;
  localparam logic [3:0] OP_PASSKEY_NTF  = 4'd5;
  localparam logic [3:0] OP_SP_COMPLETE  = 4'd6;
  localparam logic [3:0] OP_LINK_KEY     = 4'd7;
  localparam logic [3:0] OP_AUTH_DONE    = 4'd8;
  localparam logic [3:0] OP_ENC_CHANGE   = 4'd9;

  // Status codes
  localparam logic [2:0] ST_SUCCESS       = 3'd0;
  localparam logic [2:0] ST_NOT_READY     = 3'd1;
  localparam logic [2:0] ST_CANCELED      = 3'd2;
  localparam logic [2:0] ST_NOT_SUPPORTED = 3'd3;
  localparam logic [2:0] ST_FAILED        = 3'd4;
  localparam logic [2:0] ST_CONTROLLER    = 3'd5;

  // User reply codes
  localparam logic [1:0] UR_NONE         = 2'd0;
  localparam logic [1:0] UR_REJECT       = 2'd1;
  localparam logic [1:0] UR_ACCEPT       = 2'd2;
  localparam logic [1:0] UR_PASSKEY_ZERO = 2'd3;

  // IO capabilities
  localparam logic [1:0] CAP_KEYBOARD = 2'd2;
  localparam logic [1:0] CAP_NONE     = 2'd3;

  // Configuration registers
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELEGATE_PRESENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IOCAP      = 2'd1;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] remote_iocap;
    logic [7:0] hci_status;
    logic       encryption_enabled;
    logic       encryption_start_ok;
  } in_item_t;

  typedef struct packed {
    logic       send_auth_request;
    logic       iocap_reply_valid;
    logic [1:0] iocap_reply;
    logic [1:0] user_reply;
    logic       start_encryption;
    logic       requester_status_valid;
    logic [2:0] requester_status;
    logic       broadcast_valid;
    logic [2:0] broadcast_status;
    logic [4:0] waiters_notified;
    logic [7:0] error_code;
  } out_item_t;

  // User event that follows from the two IO capabilities
  function automatic user_ev_t choose_event(logic [1:0] host_cap, logic [1:0] remote_cap);
    user_ev_t ev;
    if (host_cap == CAP_NONE || remote_cap == CAP_NONE) ev = EV_CONFIRM;
    else if (host_cap == CAP_KEYBOARD) ev = EV_PASSKEY_REQ;
    else if (remote_cap == CAP_KEYBOARD) ev = EV_PASSKEY_NOTIFY;
    else ev = EV_CONFIRM;
    return ev;
  endfunction

  // Mode that waits for a given user event
  function automatic mode_t mode_for_event(user_ev_t ev);
    mode_t m;
    case (ev)
      EV_PASSKEY_REQ:    m = M_WAIT_PASSKEY_REQ;
      EV_PASSKEY_NOTIFY: m = M_WAIT_PASSKEY_NOTIFY;
      default:           m = M_WAIT_CONFIRM;
    endcase
    return m;
  endfunction

endpackage

[rtl/bpsm_in_if.sv]
// Event input channel of the pairing sequencer: valid, ready, event payload.
// Depends on bpsm_pkg.
interface bpsm_in_if;
  logic               valid;
  logic               ready;
  bpsm_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/bpsm_out_if.sv]
// Result channel of the pairing sequencer: valid, ready, result payload.
// Depends on bpsm_pkg.
interface bpsm_out_if;
  logic                valid;
  logic                ready;
  bpsm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/bpsm_cfg_if.sv]
// Configuration write channel: valid, ready, register index and write data.
// Depends on bpsm_pkg.
interface bpsm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [bpsm_pkg::CFG_IDX_W-1:0]      index;
  logic [bpsm_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/bredr_pairing_state_machine_unit.sv]
// A result is registered into the output register, or the skid if that is full.
// Throughput: one event per cycle; the state update is a single registered step.
// A two-entry result buffer (output register plus skid) keeps in_ch ready
// while one result waits; in_ch stalls only when both entries are full.
// Reset (rst_n low, synchronous): mode idle, counters and flags cleared,
// no delegate, host IO capability 3 (none), result buffer empty.
`include "assert_macros.svh"

module bredr_pairing_state_machine_unit #(
  parameter int unsigned MAX_WAITERS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  bpsm_in_if.sink      in_ch,
  bpsm_out_if.source   out_ch,
  bpsm_cfg_if.sink     cfg_ch
);
  import bpsm_pkg::*;

  localparam int unsigned WC_W = $clog2(MAX_WAITERS + 1);
  localparam logic [WC_W-1:0] WC_MAX = WC_W'(MAX_WAITERS);

  // Configuration
  logic       delegate_r;
  logic [1:0] host_iocap_r;

  // Pairing state
  mode_t           mode_r, mode_nxt;
  logic            active_r, active_nxt;
  logic            initiator_r, initiator_nxt;
  logic [1:0]      own_cap_r, own_cap_nxt;
  logic [1:0]      partner_cap_r, partner_cap_nxt;
  user_ev_t        exp_ev_r, exp_ev_nxt;
  logic [WC_W-1:0] waiter_cnt_r, waiter_cnt_nxt;

  // Result buffer
  out_item_t out_data_r, skid_data_r;
  logic      out_valid_r, skid_valid_r;

  in_item_t  item;
  out_item_t res;
  logic      release_q;
  logic      in_fire, out_fire, out_free;

  assign item     = in_ch.data;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_valid_r && out_ch.ready;
  assign out_free = !out_valid_r || out_fire;

  assign in_ch.ready  = !skid_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign cfg_ch.ready = 1'b1;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delegate_r   <= 1'b0;
      host_iocap_r <= CAP_NONE;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_DELEGATE_PRESENT: delegate_r   <= cfg_ch.data[0];
        CFG_LOCAL_IOCAP:      host_iocap_r <= cfg_ch.data[1:0];
        default: ;
      endcase
    end
  end

  // Result of the current event; release_q marks a broadcast that frees waiters
  always_comb begin
    res       = '0;
    release_q = 1'b0;
    unique case (item.op)
      OP_INITIATE: begin
        if (!delegate_r) begin
          res.requester_status_valid = 1'b1;
          res.requester_status       = ST_NOT_READY;
        end else if (mode_r == M_IDLE) begin
          res.send_auth_request = 1'b1;
        end else if (!active_r) begin
          res.requester_status_valid = 1'b1;
          res.requester_status       = ST_CANCELED;
        end
      end
      OP_IOCAP_REQ: begin
        if (mode_r == M_INIT_STARTED || mode_r == M_RESP_WAIT_IOCAP_REQ) begin
          if (!delegate_r) begin
            res.broadcast_valid  = 1'b1;
            res.broadcast_status = ST_NOT_READY;
            release_q            = 1'b1;
          end else begin
            res.iocap_reply_valid = 1'b1;
            res.iocap_reply       = host_iocap_r;
          end
        end else begin
          res.broadcast_valid  = 1'b1;
          res.broadcast_status = ST_NOT_SUPPORTED;
          release_q            = 1'b1;
        end
      end
      OP_IOCAP_RESP: begin
        if (mode_r != M_IDLE && mode_r != M_INIT_WAIT_IOCAP_RESP) begin
          res.broadcast_valid  = 1'b1;
          res.broadcast_status = ST_NOT_SUPPORTED;
          release_q            = 1'b1;
        end
      end
      OP_CONFIRM: begin
        if (mode_r != M_WAIT_CONFIRM) begin
          res.broadcast_valid  = 1'b1;
          res.broadcast_status = ST_NOT_SUPPORTED;
          res.user_reply       = UR_REJECT;
          release_q            = 1'b1;
        end else begin
          res.user_reply = UR_ACCEPT;
        end
      end
      OP_PASSKEY_REQ: begin
        if (mode_r != M_WAIT_PASSKEY_REQ) begin
          res.broadcast_valid  = 1'b1;
          res.broadcast_status = ST_NOT_SUPPORTED;
          res.user_reply       = UR_REJECT;
          release_q            = 1'b1;
        end else begin
          res.user_reply = UR_PASSKEY_ZERO;
        end
      end
      OP_PASSKEY_NTF: begin
        if (mode_r != M_WAIT_PASSKEY_NOTIFY) begin
          res.broadcast_valid  = 1'b1;
          res.broadcast_status = ST_NOT_SUPPORTED;
          release_q            = 1'b1;
        end
      end
      OP_SP_COMPLETE: begin
        if (mode_r != M_WAIT_PAIRING_COMPLETE) begin
          res.broadcast_valid  = 1'b1;
          res.broadcast_status = ST_NOT_SUPPORTED;
          release_q            = 1'b1;
        end else if (item.hci_status != 8'd0) begin
          res.broadcast_valid  = 1'b1;
          res.broadcast_status = ST_CONTROLLER;
          res.error_code       = item.hci_status;
          release_q            = 1'b1;
        end
      end
      OP_LINK_KEY: begin
        if (mode_r != M_WAIT_LINK_KEY) begin
          res.broadcast_valid  = 1'b1;
          res.broadcast_status = ST_NOT_SUPPORTED;
          release_q            = 1'b1;
        end else if (!initiator_r) begin
          // responder starts encryption; a refusal fails without releasing
          if (item.encryption_start_ok) begin
            res.start_encryption = 1'b1;
          end else begin
            res.broadcast_valid  = 1'b1;
            res.broadcast_status = ST_FAILED;
          end
        end
      end
      OP_AUTH_DONE: begin
        if (mode_r != M_INIT_STARTED && mode_r != M_INIT_WAIT_AUTH) begin
          res.broadcast_valid  = 1'b1;
          res.broadcast_status = ST_NOT_SUPPORTED;
          release_q            = 1'b1;
        end else if (item.hci_status != 8'd0) begin
          res.broadcast_valid  = 1'b1;
          res.broadcast_status = ST_CONTROLLER;
          res.error_code       = item.hci_status;
          release_q            = 1'b1;
        end else if (item.encryption_start_ok) begin
          res.start_encryption = 1'b1;
        end else begin
          res.broadcast_valid  = 1'b1;
          res.broadcast_status = ST_FAILED;
        end
      end
      OP_ENC_CHANGE: begin
        if (mode_r == M_WAIT_ENCRYPTION) begin
          res.broadcast_valid = 1'b1;
          release_q           = 1'b1;
          if (item.hci_status != 8'd0) begin
            res.broadcast_status = ST_CONTROLLER;
            res.error_code       = item.hci_status;
          end else if (!item.encryption_enabled) begin
            res.broadcast_status = ST_FAILED;
          end else begin
            res.broadcast_status = ST_SUCCESS;
          end
        end
      end
      default: ;
    endcase
    if (release_q && active_r) res.waiters_notified = 5'(waiter_cnt_r);
  end

  // Next pairing state for the current event
  always_comb begin
    mode_nxt        = mode_r;
    active_nxt      = active_r;
    initiator_nxt   = initiator_r;
    own_cap_nxt     = own_cap_r;
    partner_cap_nxt = partner_cap_r;
    exp_ev_nxt      = exp_ev_r;
    waiter_cnt_nxt  = waiter_cnt_r;
    unique case (item.op)
      OP_INITIATE: begin
        if (delegate_r && mode_r == M_IDLE) begin
          active_nxt     = 1'b1;
          initiator_nxt  = 1'b1;
          waiter_cnt_nxt = WC_W'(1);
          mode_nxt       = M_INIT_STARTED;
        end else if (delegate_r && active_r && waiter_cnt_r < WC_MAX) begin
          waiter_cnt_nxt = waiter_cnt_r + WC_W'(1);
        end
      end
      OP_IOCAP_REQ: begin
        if (mode_r == M_INIT_STARTED || mode_r == M_RESP_WAIT_IOCAP_REQ) begin
          if (!delegate_r) begin
            mode_nxt = M_IDLE;
          end else begin
            own_cap_nxt = host_iocap_r;
            if (mode_r == M_INIT_STARTED) begin
              mode_nxt = M_INIT_WAIT_IOCAP_RESP;
            end else begin
              exp_ev_nxt = choose_event(host_iocap_r, partner_cap_r);
              mode_nxt   = mode_for_event(choose_event(host_iocap_r, partner_cap_r));
            end
          end
        end else begin
          mode_nxt = M_FAILED;
        end
      end
      OP_IOCAP_RESP: begin
        if (mode_r == M_IDLE) begin
          active_nxt      = 1'b1;
          initiator_nxt   = 1'b0;
          waiter_cnt_nxt  = '0;
          partner_cap_nxt = item.remote_iocap;
          mode_nxt        = M_RESP_WAIT_IOCAP_REQ;
        end else if (mode_r == M_INIT_WAIT_IOCAP_RESP) begin
          partner_cap_nxt = item.remote_iocap;
          exp_ev_nxt      = choose_event(own_cap_r, item.remote_iocap);
          mode_nxt        = mode_for_event(choose_event(own_cap_r, item.remote_iocap));
        end else begin
          mode_nxt = M_FAILED;
        end
      end
      OP_CONFIRM:
        mode_nxt = (mode_r == M_WAIT_CONFIRM) ? M_WAIT_PAIRING_COMPLETE : M_FAILED;
      OP_PASSKEY_REQ:
        mode_nxt = (mode_r == M_WAIT_PASSKEY_REQ) ? M_WAIT_PAIRING_COMPLETE : M_FAILED;
      OP_PASSKEY_NTF:
        mode_nxt = (mode_r == M_WAIT_PASSKEY_NOTIFY) ? M_WAIT_PAIRING_COMPLETE : M_FAILED;
      OP_SP_COMPLETE: begin
        if (mode_r == M_WAIT_PAIRING_COMPLETE && item.hci_status == 8'd0) begin
          mode_nxt = M_WAIT_LINK_KEY;
        end else begin
          mode_nxt = M_FAILED;
        end
      end
      OP_LINK_KEY: begin
        if (mode_r != M_WAIT_LINK_KEY) mode_nxt = M_FAILED;
        else if (initiator_r) mode_nxt = M_INIT_WAIT_AUTH;
        else mode_nxt = item.encryption_start_ok ? M_WAIT_ENCRYPTION : M_FAILED;
      end
      OP_AUTH_DONE: begin
        if ((mode_r == M_INIT_STARTED || mode_r == M_INIT_WAIT_AUTH) &&
            item.hci_status == 8'd0 && item.encryption_start_ok) begin
          mode_nxt = M_WAIT_ENCRYPTION;
        end else begin
          mode_nxt = M_FAILED;
        end
      end
      OP_ENC_CHANGE: begin
        if (mode_r == M_WAIT_ENCRYPTION) begin
          if (item.hci_status == 8'd0 && item.encryption_enabled) mode_nxt = M_IDLE;
          else mode_nxt = M_FAILED;
        end
      end
      default: ;
    endcase
    // a releasing broadcast (release_q) with a pairing held releases all queued initiators
    if (release_q && active_r) begin
      waiter_cnt_nxt = '0;
      active_nxt     = 1'b0;
    end
  end

  // Pairing state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= M_IDLE;
      active_r      <= 1'b0;
      initiator_r   <= 1'b0;
      own_cap_r     <= '0;
      partner_cap_r <= '0;
      exp_ev_r      <= EV_CONFIRM;
      waiter_cnt_r  <= '0;
    end else if (in_fire) begin
      mode_r        <= mode_nxt;
      active_r      <= active_nxt;
      initiator_r   <= initiator_nxt;
      own_cap_r     <= own_cap_nxt;
      partner_cap_r <= partner_cap_nxt;
      exp_ev_r      <= exp_ev_nxt;
      waiter_cnt_r  <= waiter_cnt_nxt;
    end
  end

  // Result buffer valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (in_fire) begin
      if (out_free) out_valid_r <= 1'b1;
      else skid_valid_r <= 1'b1;
    end else if (out_fire) begin
      if (skid_valid_r) skid_valid_r <= 1'b0;
      else out_valid_r <= 1'b0;
    end
  end

  // Result buffer payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (out_free) out_data_r <= res;
      else skid_data_r <= res;
    end else if (out_fire && skid_valid_r) begin
      out_data_r <= skid_data_r;
    end
  end

  // Checks
  `BPSM_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `BPSM_ASSERT_IMP(a_idle_no_waiters, clk, rst_n, !active_r, waiter_cnt_r == '0)
  `BPSM_ASSERT_IMP(a_waiters_bounded, clk, rst_n, 1'b1, waiter_cnt_r <= WC_MAX)
  `BPSM_ASSERT_IMP(a_pk_ev, clk, rst_n, mode_r == M_WAIT_PASSKEY_REQ, exp_ev_r == EV_PASSKEY_REQ)
  `BPSM_ASSERT_NXT(a_result_follows, clk, rst_n, in_fire, out_valid_r)

endmodule
